// ===== rtl/seven_segment_scan_driver_assert.svh =====
// assertion macros used by the seven-segment scan driver core module
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("seven segment scan driver check failed");

// next-cycle implication, disabled during reset
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("seven segment scan driver check failed");

`endif

// ===== rtl/ssd_pkg.sv =====
// types, codes and font table of the seven-segment scan driver
package ssd_pkg;

	localparam int DIGIT_W  = 3;
	localparam int SYMBOL_W = 6;
	localparam int SEG_W    = 8;
	localparam int PADDR_W  = 3;

	localparam logic [SYMBOL_W-1:0] SYM_COUNT = 6'd50;
	localparam logic [SYMBOL_W-1:0] SYM_BLANK = 6'd34;
	localparam logic [SYMBOL_W-1:0] SYM_EIGHT = 6'd8;
	localparam logic [SEG_W-1:0]    POINT_BIT = 8'h80;
	localparam logic [SEG_W-1:0]    FONT_MASK = 8'h7F;

	// register index, taken from paddr bit 2
	localparam logic REG_COMMON_CATHODE = 1'b0;
	localparam logic REG_DATA_INVERTED  = 1'b1;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_SET_SYMBOL = 3'd1,
		MODE_SET_POINT  = 3'd2,
		MODE_BLANK      = 3'd3,
		MODE_EIGHTS     = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]          mode;
		logic [DIGIT_W-1:0]  digit;
		logic [SYMBOL_W-1:0] symbol;
		logic                point_on;
	} item_t;

	typedef struct packed {
		logic common_cathode;
		logic data_inverted;
	} cfg_t;

	// active-low font table
	function automatic logic [SEG_W-1:0] ssd_font(input logic [SYMBOL_W-1:0] sym);
		logic [SEG_W-1:0] f;
		case (sym)
			6'd0:  f = 8'hC0;
			6'd1:  f = 8'hF9;
			6'd2:  f = 8'hA4;
			6'd3:  f = 8'hB0;
			6'd4:  f = 8'h99;
			6'd5:  f = 8'h92;
			6'd6:  f = 8'h82;
			6'd7:  f = 8'hF8;
			6'd8:  f = 8'h80;
			6'd9:  f = 8'h90;
			6'd10: f = 8'h88;
			6'd11: f = 8'h83;
			6'd12: f = 8'hC6;
			6'd13: f = 8'hA1;
			6'd14: f = 8'h86;
			6'd15: f = 8'h8E;
			6'd16: f = 8'h90;
			6'd17: f = 8'h8B;
			6'd18: f = 8'hCF;
			6'd19: f = 8'hF1;
			6'd20: f = 8'hFF;
			6'd21: f = 8'hF7;
			6'd22: f = 8'hAF;
			6'd23: f = 8'h92;
			6'd24: f = 8'h87;
			6'd25: f = 8'hCE;
			6'd26: f = 8'hC1;
			6'd27: f = 8'h9B;
			6'd28: f = 8'h8C;
			6'd29: f = 8'hE3;
			6'd30: f = 8'h89;
			6'd31: f = 8'hA1;
			6'd32: f = 8'hC7;
			6'd33: f = 8'h80;
			6'd34: f = 8'hFF;
			6'd35: f = 8'h84;
			6'd36: f = 8'hA0;
			6'd37: f = 8'h83;
			6'd38: f = 8'h98;
			6'd39: f = 8'hA7;
			6'd40: f = 8'hA3;
			6'd41: f = 8'hB6;
			6'd42: f = 8'hFE;
			6'd43: f = 8'hFD;
			6'd44: f = 8'hFB;
			6'd45: f = 8'hF7;
			6'd46: f = 8'hEF;
			6'd47: f = 8'hDF;
			6'd48: f = 8'hBF;
			6'd49: f = 8'h00;
			default: f = 8'hFF;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/ssd_cfg.sv =====
// configuration registers behind the register port
module ssd_cfg
	import ssd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic reg_idx;
	logic wr_en;
	cfg_t cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COMMON_CATHODE: cfg_q.common_cathode <= pwdata[0];
				REG_DATA_INVERTED:  cfg_q.data_inverted  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_COMMON_CATHODE: prdata = {31'd0, cfg_q.common_cathode};
			REG_DATA_INVERTED:  prdata = {31'd0, cfg_q.data_inverted};
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ssd_core.sv =====
// digit stores, scan pointer, segment lookup and result register
module ssd_core
	import ssd_pkg::*;
#(
	parameter int DIGITS = 4
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	input  item_t               item,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SEG_W-1:0]    segments,
	output logic [SEG_W-1:0]    digit_enable,
	output logic [SYMBOL_W-1:0] stored_symbol
);

	`include "seven_segment_scan_driver_assert.svh"

	localparam logic [DIGIT_W:0]   DIGIT_COUNT = (DIGIT_W+1)'(DIGITS);
	localparam logic [DIGIT_W-1:0] LAST_PTR    = DIGIT_W'(DIGITS - 1);

	logic [SYMBOL_W-1:0] sym_q [DIGITS];
	logic                pt_q  [DIGITS];
	logic [SYMBOL_W-1:0] sym_d [DIGITS];
	logic                pt_d  [DIGITS];
	logic [DIGIT_W-1:0]  ptr_q, ptr_d;
	logic [SEG_W-1:0]    seg_hold_q, seg_hold_d;
	logic [SEG_W-1:0]    en_hold_q, en_hold_d;
	logic [SYMBOL_W-1:0] stored_q, stored_d;
	logic                out_valid_q;
	logic                take;
	logic                digit_ok;
	logic [SYMBOL_W-1:0] sym_clamped;
	logic [SYMBOL_W-1:0] cur_sym;
	logic                cur_pt;
	logic [SEG_W-1:0]    font;
	logic [SEG_W-1:0]    seg_new;

	assign in_ready      = !out_valid_q || out_ready;
	assign take          = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign segments      = seg_hold_q;
	assign digit_enable  = en_hold_q;
	assign stored_symbol = stored_q;

	assign digit_ok    = {1'b0, item.digit} < DIGIT_COUNT;
	assign sym_clamped = (item.symbol < SYM_COUNT) ? item.symbol : SYM_BLANK;

	// digit under the scan pointer
	always_comb begin
		cur_sym = SYM_BLANK;
		cur_pt  = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (ptr_q == DIGIT_W'(i)) begin
				cur_sym = sym_q[i];
				cur_pt  = pt_q[i];
			end
		end
	end

	// font lookup and polarity
	always_comb begin
		font = ssd_font(cur_sym);
		if (cfg.data_inverted) begin
			seg_new = ~font;
		end else if (cfg.common_cathode) begin
			seg_new = cur_pt ? ~(font | POINT_BIT) : ~(font & FONT_MASK);
		end else begin
			seg_new = cur_pt ? (font & FONT_MASK) : (font | POINT_BIT);
		end
	end

	// next state for the stores, pointer and held outputs
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			sym_d[i] = sym_q[i];
			pt_d[i]  = pt_q[i];
		end
		ptr_d      = ptr_q;
		seg_hold_d = seg_hold_q;
		en_hold_d  = en_hold_q;
		case (item.mode)
			MODE_TICK: begin
				seg_hold_d = seg_new;
				en_hold_d  = SEG_W'(1) << ptr_q;
				ptr_d      = (ptr_q == LAST_PTR) ? '0 : ptr_q + DIGIT_W'(1);
			end
			MODE_SET_SYMBOL: begin
				for (int i = 0; i < DIGITS; i++) begin
					if (digit_ok && item.digit == DIGIT_W'(i)) sym_d[i] = sym_clamped;
				end
			end
			MODE_SET_POINT: begin
				for (int i = 0; i < DIGITS; i++) begin
					if (digit_ok && item.digit == DIGIT_W'(i)) pt_d[i] = item.point_on;
				end
			end
			MODE_BLANK: begin
				for (int i = 0; i < DIGITS; i++) begin
					sym_d[i] = SYM_BLANK;
					pt_d[i]  = 1'b0;
				end
			end
			MODE_EIGHTS: begin
				for (int i = 0; i < DIGITS; i++) begin
					sym_d[i] = SYM_EIGHT;
					pt_d[i]  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// stored symbol of the addressed digit after the update
	always_comb begin
		stored_d = SYM_BLANK;
		for (int i = 0; i < DIGITS; i++) begin
			if (item.digit == DIGIT_W'(i)) stored_d = sym_d[i];
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				sym_q[i] <= SYM_BLANK;
				pt_q[i]  <= 1'b0;
			end
			ptr_q       <= '0;
			seg_hold_q  <= '0;
			en_hold_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				for (int i = 0; i < DIGITS; i++) begin
					sym_q[i] <= sym_d[i];
					pt_q[i]  <= pt_d[i];
				end
				ptr_q      <= ptr_d;
				seg_hold_q <= seg_hold_d;
				en_hold_q  <= en_hold_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stored symbol payload
	always_ff @(posedge clk) begin
		if (take) begin
			stored_q <= stored_d;
		end
	end

	`SSD_ASSERT_IMPL(a_enable_onehot0, clk, arst_n, 1'b1, $onehot0(en_hold_q))
	`SSD_ASSERT_IMPL(a_ptr_in_range, clk, arst_n, 1'b1, {1'b0, ptr_q} < DIGIT_COUNT)
	`SSD_ASSERT_NEXT(a_tick_enables, clk, arst_n, take && item.mode == MODE_TICK, $onehot(en_hold_q))
	`SSD_ASSERT_IMPL(a_stored_legal, clk, arst_n, out_valid_q, stored_q < SYM_COUNT)

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// Multiplexed seven-segment scan driver, top level.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle when m_tready does not stall; a beat is a store write, a scan tick or a no-op.
// Reset: symbol stores blank, points off, scan pointer, held segments and enables zero,
// configuration registers zero; no clearing pass, the block takes beats right after reset.
module seven_segment_scan_driver
	import ssd_pkg::*;
#(
	parameter int DIGITS = 4
)
(
	input  logic               clk,
	input  logic               arst_n,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,  // digit[2:0], symbol[8:3], point_on[9], zero fill
	input  logic [2:0]         s_tuser,  // mode[2:0]
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata   // segments[7:0], digit_enable[15:8], stored_symbol[21:16]
);

	cfg_t                cfg;
	item_t               item_s1;
	logic                valid_s1;
	logic                core_ready;
	logic [SEG_W-1:0]    segments;
	logic [SEG_W-1:0]    digit_enable;
	logic [SYMBOL_W-1:0] stored_symbol;

	assign s_tready = !valid_s1 || core_ready;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode     <= s_tuser;
			item_s1.digit    <= s_tdata[2:0];
			item_s1.symbol   <= s_tdata[8:3];
			item_s1.point_on <= s_tdata[9];
		end
	end

	ssd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssd_core #(
		.DIGITS (DIGITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (valid_s1),
		.item          (item_s1),
		.in_ready      (core_ready),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.segments      (segments),
		.digit_enable  (digit_enable),
		.stored_symbol (stored_symbol)
	);

	// result beat packing
	assign m_tdata = {2'b00, stored_symbol, digit_enable, segments};

endmodule

// ===== tb/sv/scan_driver_checker.sv =====
// checker for the seven-segment scan driver: tracks registers, predicts and compares result beats
module scan_driver_checker
	import ssd_pkg::*;
#(
	parameter int DIGITS = 4
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [15:0]        s_tdata,  // digit[2:0], symbol[8:3], point_on[9], zero fill
	input  logic [2:0]         s_tuser,  // mode[2:0]
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [23:0]        m_tdata,  // segments[7:0], digit_enable[15:8], stored_symbol[21:16]
	output int                 mismatches,
	output int                 outstanding,
	output int                 commands_seen,
	output int                 frames_seen
);

	// active-low glyph bytes, symbol 49 in the top byte down to symbol 0 in the bottom byte
	localparam logic [50*8-1:0] GLYPHS = {
		8'h00, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE, 8'hB6, 8'hA3,
		8'hA7, 8'h98, 8'h83, 8'hA0, 8'h84, 8'hFF, 8'h80, 8'hC7, 8'hA1, 8'h89,
		8'hE3, 8'h8C, 8'h9B, 8'hC1, 8'hCE, 8'h87, 8'h92, 8'hAF, 8'hF7, 8'hFF,
		8'hF1, 8'hCF, 8'h8B, 8'h90, 8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88,
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic [SEG_W-1:0]    segments;
		logic [7:0]          enables;
		logic [SYMBOL_W-1:0] symbol;
	} frame_t;

	// shadow of the display state and registers
	logic [SYMBOL_W-1:0] digit_symbols [8];
	logic                digit_points  [8];
	logic [2:0]          scan_ptr;
	logic [SEG_W-1:0]    seg_hold;
	logic [7:0]          en_hold;
	logic                cathode;
	logic                inverted;

	frame_t frames_due [$];
	int     err_n = 0;
	int     cmd_n = 0;
	int     frame_n = 0;

	// pin byte for one digit under the current polarity settings
	function automatic logic [SEG_W-1:0] pin_byte(input logic [2:0] d);
		logic [SEG_W-1:0] f;
		f = GLYPHS[int'(digit_symbols[d])*8 +: 8];
		if (inverted)
			return ~f;
		else if (cathode)
			return digit_points[d] ? ~(f | POINT_BIT) : ~(f & FONT_MASK);
		else
			return digit_points[d] ? (f & FONT_MASK) : (f | POINT_BIT);
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		err_n++;
	endtask

	// apply one command beat to the shadow state and queue the frame it produces
	task automatic apply_command(input logic [2:0] m, input logic [2:0] d,
			input logic [SYMBOL_W-1:0] sym, input logic pt);
		case (m)
			MODE_TICK: begin
				seg_hold = pin_byte(scan_ptr);
				en_hold  = 8'b1 << scan_ptr;
				if (int'(scan_ptr) + 1 >= DIGITS)
					scan_ptr = '0;
				else
					scan_ptr = scan_ptr + 3'd1;
			end
			MODE_SET_SYMBOL: begin
				if (int'(d) < DIGITS)
					digit_symbols[d] = (sym < SYM_COUNT) ? sym : SYM_BLANK;
			end
			MODE_SET_POINT: begin
				if (int'(d) < DIGITS)
					digit_points[d] = pt;
			end
			MODE_BLANK: begin
				for (int i = 0; i < DIGITS && i < 8; i++) begin
					digit_symbols[i] = SYM_BLANK;
					digit_points[i]  = 1'b0;
				end
			end
			MODE_EIGHTS: begin
				for (int i = 0; i < DIGITS && i < 8; i++) begin
					digit_symbols[i] = SYM_EIGHT;
					digit_points[i]  = 1'b1;
				end
			end
			default: ;
		endcase
		frames_due.push_back('{segments: seg_hold, enables: en_hold, symbol: digit_symbols[d]});
	endtask

	// watch the three ports at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		frame_t want;
		frame_t got;
		logic   reg_now;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				digit_symbols[i] = SYM_BLANK;
				digit_points[i]  = 1'b0;
			end
			scan_ptr = '0;
			seg_hold = '0;
			en_hold  = '0;
			cathode  = 1'b0;
			inverted = 1'b0;
			frames_due.delete();
		end else begin
			// result beat against the oldest frame due
			if (m_tvalid && m_tready) begin
				frame_n++;
				got = '{segments: m_tdata[7:0], enables: m_tdata[15:8], symbol: m_tdata[21:16]};
				if (frames_due.size() == 0) begin
					flag("result beat with no frame due", '0, m_tdata);
				end else begin
					want = frames_due.pop_front();
					if (got.segments != want.segments)
						flag("segments", want.segments, got.segments);
					if (got.enables != want.enables)
						flag("digit_enable", want.enables, got.enables);
					if (got.symbol != want.symbol)
						flag("stored_symbol", want.symbol, got.symbol);
				end
			end
			// command beat
			if (s_tvalid && s_tready) begin
				cmd_n++;
				apply_command(s_tuser, s_tdata[2:0], s_tdata[8:3], s_tdata[9]);
			end
			// register access
			if (psel && penable && pready) begin
				reg_now = (paddr[2] == REG_DATA_INVERTED) ? inverted : cathode;
				if (pwrite) begin
					if (paddr[2] == REG_COMMON_CATHODE)
						cathode = pwdata[0];
					else
						inverted = pwdata[0];
				end else if (prdata != {31'b0, reg_now}) begin
					flag("register read", {31'b0, reg_now}, prdata);
				end
			end
		end
		mismatches    <= err_n;
		outstanding   <= frames_due.size();
		commands_seen <= cmd_n;
		frames_seen   <= frame_n;
	end

endmodule

// ===== tb/sv/seven_segment_scan_driver_tb.sv =====
// top of the seven-segment scan driver testbench: clock, reset, command stimulus and verdict
module seven_segment_scan_driver_tb;
	import ssd_pkg::*;

	localparam int DIGITS      = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 275;

	// mode codes the block leaves unused
	localparam logic [2:0] MODE_SPARE_FIRST = MODE_EIGHTS + 3'd1;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	logic [15:0]        s_tdata;  // digit[2:0], symbol[8:3], point_on[9], zero fill
	logic [2:0]         s_tuser;  // mode[2:0]
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;  // segments[7:0], digit_enable[15:8], stored_symbol[21:16]

	int mismatches;
	int outstanding;
	int commands_seen;
	int frames_seen;
	int sender_idle   = 0;
	int receiver_idle = 0;
	int quiet         = 0;

	seven_segment_scan_driver #(.DIGITS(DIGITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	scan_driver_checker #(.DIGITS(DIGITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .outstanding(outstanding),
		.commands_seen(commands_seen), .frames_seen(frames_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_idle);
	end

	// watchdog on cycles with no beat on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet <= 0;
		end else if (quiet + 1 >= QUIET_LIMIT) begin
			$display("no beat accepted for %0d cycles, %0d frames still due", QUIET_LIMIT,
				outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one command beat, with a random gap ahead of it
	task automatic send_item(input logic [2:0] m, input logic [2:0] d,
			input logic [SYMBOL_W-1:0] sym, input logic pt);
		if ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, pt, sym, d};
		s_tuser  <= m;
		do @(posedge clk); while (!s_tready);
	endtask

	// random command, mostly ticks and writes to the populated digits
	task automatic send_random_item();
		int         r;
		logic [2:0] m;
		logic [2:0] d;
		r = $urandom_range(99);
		if (r < 40)
			m = MODE_TICK;
		else if (r < 60)
			m = MODE_SET_SYMBOL;
		else if (r < 75)
			m = MODE_SET_POINT;
		else if (r < 81)
			m = MODE_BLANK;
		else if (r < 88)
			m = MODE_EIGHTS;
		else
			m = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
		if ($urandom_range(99) < 75)
			d = 3'($urandom_range(DIGITS - 1));
		else
			d = 3'($urandom_range(7));
		send_item(m, d, 6'($urandom_range(63)), 1'($urandom_range(1)));
	endtask

	// stop sending and wait for every frame due, plus the pipeline depth
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic idx, input logic val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {31'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write both polarity registers and read each back
	task automatic set_polarity(input logic cc, input logic di);
		reg_access(1'b1, REG_COMMON_CATHODE, cc);
		reg_access(1'b0, REG_COMMON_CATHODE, 1'b0);
		reg_access(1'b1, REG_DATA_INVERTED, di);
		reg_access(1'b0, REG_DATA_INVERTED, 1'b0);
	endtask

	initial begin
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		arst_n   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands under reset polarity
		sender_idle   = 35;
		receiver_idle = 81;
		send_item(MODE_SPARE_LAST, 3'd7, 6'd63, 1'b1);   // unused mode before any tick
		send_item(MODE_SPARE_FIRST, 3'd0, 6'd0, 1'b0);
		send_item(MODE_TICK, 3'd0, 6'd0, 1'b0);          // blank digit from reset
		send_item(MODE_SET_SYMBOL, 3'd0, 6'd0, 1'b0);
		send_item(MODE_SET_SYMBOL, 3'd1, SYM_COUNT - 6'd1, 1'b0);
		send_item(MODE_SET_SYMBOL, 3'd2, 6'd63, 1'b1);   // out of range stores blank
		send_item(MODE_SET_SYMBOL, 3'd3, SYM_COUNT, 1'b0);
		send_item(MODE_SET_SYMBOL, 3'd7, 6'd5, 1'b0);    // digit past the last one
		send_item(MODE_SET_POINT, 3'd1, 6'd0, 1'b1);
		send_item(MODE_SET_POINT, 3'd3, 6'd63, 1'b1);
		send_item(MODE_SET_POINT, 3'd6, 6'd0, 1'b1);     // ignored, past the last digit
		repeat (DIGITS + 1) send_item(MODE_TICK, 3'd2, 6'd0, 1'b0);  // pointer wraps
		send_item(MODE_EIGHTS, 3'd3, 6'd0, 1'b0);
		send_item(MODE_TICK, 3'd0, 6'd0, 1'b0);
		send_item(MODE_TICK, 3'd5, 6'd0, 1'b0);
		send_item(MODE_BLANK, 3'd1, 6'd0, 1'b0);
		send_item(MODE_TICK, 3'd1, 6'd0, 1'b0);
		send_item(MODE_SPARE_FIRST + 3'd1, 3'd3, 6'd42, 1'b1);

		// random phases, each under a polarity and idle profile set at its start
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			sender_idle   = (phase < 2) ? 35 : (phase < 4) ? 81 : 0;
			receiver_idle = (phase < 2) ? 81 : (phase < 4) ? 35 : 0;
			set_polarity(phase % 2 == 0, phase >= 2);
			repeat (PHASE_ITEMS) send_random_item();
		end
		settle();

		$display("run covered %0d command beats and %0d result beats", commands_seen, frames_seen);
		$display("under all four polarity settings and three idle profiles, %0d frames left due",
			outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
